// File: hdl/ktba_pkg.sv
// ktba_pkg: item kinds and stream widths for the k-means triangle bound assignment block.
// Used by kmeans_triangle_bound_assign and ktba_checker; no dependencies.
package ktba_pkg;

  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 80;
  localparam int OP_W     = 3;

  localparam logic [OP_W-1:0] OP_CENTROID = 3'd0;
  localparam logic [OP_W-1:0] OP_CBOUND   = 3'd1;
  localparam logic [OP_W-1:0] OP_SMALLEST = 3'd2;
  localparam logic [OP_W-1:0] OP_POINT    = 3'd3;
  localparam logic [OP_W-1:0] OP_LOWER    = 3'd4;

  localparam logic [1:0] REG_CLUSTERS = 2'd0;
  localparam logic [1:0] REG_DIMS     = 2'd1;

endpackage

// File: hdl/kmeans_triangle_bound_assign.sv
// kmeans_triangle_bound_assign: Elkan k-means point assignment with triangle bound pruning.
// Depends on ktba_pkg.
//
//  channel | direction | payload                                   | accept
//  s_*     | in        | tuser kind, tdata indices/values, tlast   | s_tvalid & s_tready
//  m_*     | out       | tdata per-cluster result, tlast on last   | m_tvalid & m_tready
//  cfg_*   | in        | cfg_index register, cfg_data value        | cfg_valid & cfg_ready
//
// Load items are written as they are accepted. A point run takes a check state, then a read and an
// evaluate state per cluster walked, plus per exact distance a multiply-accumulate (one coordinate
// per cycle from the centroid and point memories) and a bit-serial square root; then an order and
// an output state per result. Input is taken only between runs. Reset idles the sequencer and
// loads the default cluster and dimension counts; stores hold garbage until written. A stalled
// result holds until taken.
module kmeans_triangle_bound_assign
  import ktba_pkg::*;
#(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_DIMS     = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // index_a[3:0], index_b[9:4], value[41:10], upper_bound[73:42], assignment[77:74], zero
  input  logic [S_DATA_W-1:0] s_tdata,
  // operation[2:0]
  input  logic [OP_W-1:0]     s_tuser,
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  // cluster_index[3:0], lower_bound[35:4], new_assignment[39:36], new_upper_bound[71:40],
  // changed[72], distances_computed[77:73], zero
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [6:0]          cfg_data
);

  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int DM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CA_W   = $clog2(MAX_CLUSTERS * MAX_DIMS);
  localparam int MX_W   = $clog2(MAX_CLUSTERS * MAX_CLUSTERS);
  localparam int K_CAP  = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;
  localparam int ACC_W0 = 32 + $clog2(MAX_DIMS);
  localparam int ACC_W  = ACC_W0 + (ACC_W0 % 2);
  localparam int SQ_N   = ACC_W / 2;
  localparam int SN_W   = $clog2(SQ_N + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CHK  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EV   = 4'd3;
  localparam logic [3:0] S_MAC  = 4'd4;
  localparam logic [3:0] S_SQRT = 4'd5;
  localparam logic [3:0] S_ORD  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state;

  logic [4:0] cfg_k;
  logic [6:0] cfg_d;

  logic [3:0]         in_ia;
  logic [5:0]         in_ib;
  logic signed [31:0] in_val;
  logic signed [31:0] in_ub;
  logic [3:0]         in_asg;
  logic               s_acc;
  logic               ia_ok, ib_dim_ok, ib_cl_ok;
  logic               start;

  logic [15:0] cen_mem [MAX_CLUSTERS*MAX_DIMS];
  logic [15:0] pt_mem  [MAX_DIMS];
  logic [31:0] mx_mem  [MAX_CLUSTERS*MAX_CLUSTERS];
  logic [31:0] sd_mem  [MAX_CLUSTERS];
  logic [31:0] lb_mem  [MAX_CLUSTERS];
  logic [15:0] cen_q, pt_q;
  logic signed [31:0] mx_q, sd_q, lb_q;

  logic [CA_W-1:0] cen_wa, cen_ra;
  logic [MX_W-1:0] mx_wa, mx_ra;
  logic            mx_re, lb_re, lb_we;
  logic [CL_W-1:0] lb_ra, lb_wa;
  logic [31:0]     lb_wd;

  logic [CL_W-1:0] j, a, a0, k_last, tgt, a_sel;
  logic [DM_W-1:0] d, dims_last;
  logic [4:0]      k_sat;
  logic [8:0]      dims_sat;
  logic signed [31:0] u, z, dval;
  logic            first, tgt_first;
  logic [4:0]      dcount;
  logic            iss_on, p_v, s_v;
  logic [31:0]     sq;
  logic signed [16:0] diff;
  logic [33:0]     prod;
  logic [ACC_W-1:0] acc, sx, sres, sbit, trial;
  logic [SN_W-1:0] sn;
  logic            cond, j_end;

  assign in_ia  = s_tdata[3:0];
  assign in_ib  = s_tdata[9:4];
  assign in_val = s_tdata[41:10];
  assign in_ub  = s_tdata[73:42];
  assign in_asg = s_tdata[77:74];

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid & s_tready;
  assign ia_ok     = int'(in_ia) < MAX_CLUSTERS;
  assign ib_dim_ok = int'(in_ib) < MAX_DIMS;
  assign ib_cl_ok  = int'(in_ib) < MAX_CLUSTERS;
  assign start     = s_acc && (s_tuser == OP_LOWER) && s_tlast;

  assign a_sel  = (int'(in_asg) >= MAX_CLUSTERS) ? CL_W'(MAX_CLUSTERS - 1) : CL_W'(in_asg);
  assign cen_wa = CA_W'(in_ia) * CA_W'(MAX_DIMS) + CA_W'(in_ib);
  assign mx_wa  = MX_W'(in_ia) * MX_W'(MAX_CLUSTERS) + MX_W'(in_ib);
  assign cen_ra = CA_W'(tgt) * CA_W'(MAX_DIMS) + CA_W'(d);
  assign mx_ra  = MX_W'(a) * MX_W'(MAX_CLUSTERS) + MX_W'(j);

  always_comb begin
    if (cfg_k == 5'd0) k_sat = 5'd1;
    else if (int'(cfg_k) > K_CAP) k_sat = 5'(K_CAP);
    else k_sat = cfg_k;
    if (cfg_d == 7'd0) dims_sat = 9'd1;
    else if (int'(cfg_d) > MAX_DIMS) dims_sat = 9'(MAX_DIMS);
    else dims_sat = {2'b0, cfg_d};
  end

  assign z     = (lb_q > mx_q) ? lb_q : mx_q;
  assign cond  = (j != a) && (u > z);
  assign j_end = (j == k_last);
  assign dval  = 32'(sres);
  assign trial = sres + sbit;
  assign diff  = 17'(signed'(pt_q)) - 17'(signed'(cen_q));
  assign prod  = 34'(diff * diff);

  assign mx_re = (state == S_RD);
  always_comb begin
    lb_re = (state == S_RD) || (state == S_ORD);
    lb_ra = j;
    lb_we = 1'b0;
    lb_wa = j;
    lb_wd = dval;
    if (s_acc && (s_tuser == OP_LOWER) && ia_ok) begin
      lb_we = 1'b1;
      lb_wa = CL_W'(in_ia);
      lb_wd = in_val;
    end else if (state == S_SQRT && sn == '0 && !tgt_first) begin
      lb_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == OP_CENTROID && ia_ok && ib_dim_ok) cen_mem[cen_wa] <= in_val[15:0];
    cen_q <= cen_mem[cen_ra];
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == OP_POINT && ib_dim_ok) pt_mem[DM_W'(in_ib)] <= in_val[15:0];
    pt_q <= pt_mem[d];
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == OP_CBOUND && ia_ok && ib_cl_ok) mx_mem[mx_wa] <= in_val;
    if (mx_re) mx_q <= mx_mem[mx_ra];
  end

  always_ff @(posedge clk) begin
    if (s_acc && s_tuser == OP_SMALLEST && ia_ok) sd_mem[CL_W'(in_ia)] <= in_val;
    if (start) sd_q <= sd_mem[a_sel];
  end

  always_ff @(posedge clk) begin
    if (lb_we) lb_mem[lb_wa] <= lb_wd;
    if (lb_re) lb_q <= lb_mem[lb_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_k <= 5'd16;
      cfg_d <= 7'd64;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CLUSTERS) cfg_k <= cfg_data[4:0];
      else if (cfg_index == REG_DIMS) cfg_d <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    sq <= prod[31:0];
    if (rst) begin
      state  <= S_IDLE;
      iss_on <= 1'b0;
      p_v    <= 1'b0;
      s_v    <= 1'b0;
      j      <= '0;
      first  <= 1'b0;
      dcount <= '0;
    end else begin
      p_v <= iss_on;
      s_v <= p_v;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            u         <= in_ub;
            a         <= a_sel;
            a0        <= a_sel;
            k_last    <= CL_W'(k_sat - 5'd1);
            dims_last <= DM_W'(dims_sat - 9'd1);
            first     <= 1'b1;
            dcount    <= '0;
            j         <= '0;
            state     <= S_CHK;
          end
        end
        S_CHK: state <= (u > sd_q) ? S_RD : S_ORD;
        S_RD:  state <= S_EV;
        S_EV: begin
          if (cond) begin
            tgt       <= first ? a : j;
            tgt_first <= first;
            d         <= '0;
            iss_on    <= 1'b1;
            acc       <= '0;
            state     <= S_MAC;
          end else if (j_end) begin
            j     <= '0;
            state <= S_ORD;
          end else begin
            j     <= j + 1'b1;
            state <= S_RD;
          end
        end
        S_MAC: begin
          if (iss_on) begin
            if (d == dims_last) iss_on <= 1'b0;
            else d <= d + 1'b1;
          end
          if (s_v) acc <= acc + ACC_W'(sq);
          if (!iss_on && !p_v && !s_v) begin
            sx    <= acc;
            sres  <= '0;
            sbit  <= ACC_W'(1) << (ACC_W - 2);
            sn    <= SN_W'(SQ_N);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sn != '0) begin
            if (sx >= trial) begin
              sx   <= sx - trial;
              sres <= (sres >> 1) + sbit;
            end else begin
              sres <= sres >> 1;
            end
            sbit <= sbit >> 2;
            sn   <= sn - 1'b1;
          end else begin
            dcount <= dcount + 5'd1;
            if (tgt_first) begin
              u     <= dval;
              first <= 1'b0;
              state <= S_EV;
            end else begin
              if (dval < u) begin
                u <= dval;
                a <= j;
              end
              if (j_end) begin
                j     <= '0;
                state <= S_ORD;
              end else begin
                j     <= j + 1'b1;
                state <= S_RD;
              end
            end
          end
        end
        S_ORD: state <= S_OUT;
        S_OUT: begin
          if (m_tready) begin
            if (j_end) begin
              state <= S_IDLE;
            end else begin
              j     <= j + 1'b1;
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = j_end;
  assign m_tdata  = {2'b0, dcount, (a != a0), u, 4'(a), lb_q, 4'(j)};

endmodule

// File: hdl/ktba_checker.sv
// ktba_checker: port-level checks for kmeans_triangle_bound_assign, bound to the top level.
// Depends on ktba_pkg.
module ktba_checker
  import ktba_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [OP_W-1:0]     s_tuser,
  input logic                s_tlast,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic                m_tlast
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input taken during result phase");

  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == OP_LOWER && s_tlast |=> !s_tready)
    else $error("run start did not stall input");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("no return to idle after last result");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !m_tvalid ##1
      (m_tvalid && m_tdata[3:0] == $past(m_tdata[3:0], 2) + 4'd1))
    else $error("cluster index did not advance");

endmodule

bind kmeans_triangle_bound_assign ktba_checker u_ktba_checker (.*);
